FILE: hdl/mrfc_pkg.sv
package mrfc_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CRC_W   = 16;
   localparam int unsigned STAT_W  = 16;
   localparam int unsigned PLEN_W  = 8;
   localparam int unsigned HDR_CRC_BYTES = 3;

   localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
   localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
   localparam logic [BYTE_W-1:0] BROADCAST_ADDR = 8'h00;
   localparam logic [BYTE_W-1:0] SLAVE_ADDR_RESET = 8'h01;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_RXERR = 3'd1,
      ST_SHORT = 3'd2,
      ST_LONG  = 3'd3,
      ST_CRC   = 3'd4,
      ST_ADDR  = 3'd5
   } status_type;

   // reflected crc-16, one byte, eight shift steps
   function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: hdl/mrfc_if.sv
interface mrfc_req_if import mrfc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              end_of_frame;
   logic              rx_error;

   modport source (output valid, data_byte, end_of_frame, rx_error, input ready);
   modport sink   (input valid, data_byte, end_of_frame, rx_error, output ready);
endinterface

interface mrfc_rsp_if import mrfc_pkg::*; ();
   logic              valid;
   logic              ready;
   status_type        status;
   logic [BYTE_W-1:0] station;
   logic [BYTE_W-1:0] function_code;
   logic [PLEN_W-1:0] pdu_length;
   logic              is_broadcast;
   logic [STAT_W-1:0] bus_message_count;
   logic [STAT_W-1:0] comm_error_count;
   logic [STAT_W-1:0] slave_message_count;
   logic [STAT_W-1:0] no_response_count;

   modport source (output valid, status, station, function_code, pdu_length, is_broadcast,
                   bus_message_count, comm_error_count, slave_message_count,
                   no_response_count, input ready);
   modport sink   (input valid, status, station, function_code, pdu_length, is_broadcast,
                   bus_message_count, comm_error_count, slave_message_count,
                   no_response_count, output ready);
endinterface

interface mrfc_csr_if import mrfc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/modbus_rtu_frame_checker_top.sv
// Modbus RTU receive-frame checker. Bytes of a frame arrive one per beat on req_ch,
// address first and CRC high byte last, with end_of_frame on the final byte. Each byte
// goes through an input register and then the CRC/length/address logic, so a new byte
// is taken every cycle; the frame-end beat needs the result register free (or being
// drained) to move on. One result per frame is held in the result register and shown
// on rsp_ch once its last byte has left the input register, carrying status, header
// fields and the four wrapping statistics counters. The own station address is written
// through csr_ch (always ready, reset 1) and should only be changed between frames.
module modbus_rtu_frame_checker_top import mrfc_pkg::*; #(
   parameter int unsigned MIN_FRAME = 4,
   parameter int unsigned MAX_FRAME = 256
) (
   input  logic        clock,
   input  logic        reset,
   mrfc_req_if.sink    req_ch,
   mrfc_rsp_if.source  rsp_ch,
   mrfc_csr_if.sink    csr_ch
);

   localparam int unsigned CNT_W = $clog2(MAX_FRAME + 2);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);
   localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_FRAME);
   localparam logic [CNT_W-1:0] CNT_HDR = CNT_W'(HDR_CRC_BYTES);

   // configuration
   logic [BYTE_W-1:0] slave_addr_ff;

   // input register
   logic              s1_valid_ff;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_eof_ff;
   logic              s1_err_ff;

   // per-frame state
   logic [CRC_W-1:0]  crc_run_ff, crc_d0_ff;
   logic [BYTE_W-1:0] prev_byte_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [BYTE_W-1:0] first_ff, second_ff;
   logic              err_seen_ff;

   // statistics
   logic [STAT_W-1:0] bus_cnt_ff, comm_cnt_ff, slave_cnt_ff, nores_cnt_ff;

   // result register
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [BYTE_W-1:0] rsp_station_ff, rsp_func_ff;
   logic [PLEN_W-1:0] rsp_plen_ff;
   logic              rsp_bcast_ff;

   logic              req_fire, s1_advance, s1_fire, frame_end;
   logic [CRC_W-1:0]  crc_run_in, rx_crc;
   logic [CNT_W-1:0]  count_in;
   logic [BYTE_W-1:0] first_in, second_in;
   logic              err_seen_in, bcast;
   status_type        status_in;
   logic [PLEN_W-1:0] plen_in;
   logic              rsp_valid_in;

   assign csr_ch.ready = 1'b1;

   // frame-end beat waits while an untaken result sits in the output register
   assign s1_advance   = !(s1_eof_ff && rsp_valid_ff && !rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_advance;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign s1_fire      = s1_valid_ff && s1_advance;
   assign frame_end    = s1_fire && s1_eof_ff;

   always_comb begin
      err_seen_in = err_seen_ff | s1_err_ff;
      first_in    = (count_ff == '0) ? s1_byte_ff : first_ff;
      second_in   = (count_ff == CNT_W'(1)) ? s1_byte_ff : second_ff;
      crc_run_in  = crc_feed(crc_run_ff, s1_byte_ff);
      count_in    = (count_ff <= CNT_MAX) ? count_ff + CNT_W'(1) : count_ff;
      // crc received low byte first: this byte is the high half
      rx_crc      = {s1_byte_ff, prev_byte_ff};
      bcast       = (first_in == BROADCAST_ADDR);

      if (err_seen_in) begin
         status_in = ST_RXERR;
      end else if (count_in < CNT_MIN) begin
         status_in = ST_SHORT;
      end else if (count_in > CNT_MAX) begin
         status_in = ST_LONG;
      end else if (crc_d0_ff != rx_crc) begin
         status_in = ST_CRC;
      end else if (first_in != slave_addr_ff && !bcast) begin
         status_in = ST_ADDR;
      end else begin
         status_in = ST_OK;
      end

      if (count_in >= CNT_HDR && count_in <= CNT_MAX) begin
         plen_in = PLEN_W'(count_in - CNT_HDR);
      end else begin
         plen_in = '0;
      end

      rsp_valid_in = frame_end || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= SLAVE_ADDR_RESET;
      end else if (csr_ch.valid) begin
         slave_addr_ff <= csr_ch.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_ch.data_byte;
         s1_eof_ff  <= req_ch.end_of_frame;
         s1_err_ff  <= req_ch.rx_error;
      end
   end

   // crc_d0 is the crc over all but the last two bytes when the last byte is here
   always_ff @(posedge clock) begin
      if (reset || frame_end) begin
         crc_run_ff   <= CRC_INIT;
         crc_d0_ff    <= CRC_INIT;
         prev_byte_ff <= '0;
         count_ff     <= '0;
         first_ff     <= '0;
         second_ff    <= '0;
         err_seen_ff  <= 1'b0;
      end else if (s1_fire) begin
         crc_run_ff   <= crc_run_in;
         crc_d0_ff    <= crc_run_ff;
         prev_byte_ff <= s1_byte_ff;
         count_ff     <= count_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         err_seen_ff  <= err_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_cnt_ff   <= '0;
         comm_cnt_ff  <= '0;
         slave_cnt_ff <= '0;
         nores_cnt_ff <= '0;
      end else if (frame_end) begin
         if (status_in == ST_OK || status_in == ST_ADDR) begin
            bus_cnt_ff <= bus_cnt_ff + STAT_W'(1);
         end else begin
            comm_cnt_ff <= comm_cnt_ff + STAT_W'(1);
         end
         if (status_in == ST_OK) begin
            slave_cnt_ff <= slave_cnt_ff + STAT_W'(1);
            if (bcast) begin
               nores_cnt_ff <= nores_cnt_ff + STAT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_end) begin
         rsp_status_ff  <= status_in;
         rsp_station_ff <= first_in;
         rsp_func_ff    <= second_in;
         rsp_plen_ff    <= plen_in;
         rsp_bcast_ff   <= (status_in == ST_OK) && bcast;
      end
   end

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.status              = rsp_status_ff;
   assign rsp_ch.station             = rsp_station_ff;
   assign rsp_ch.function_code       = rsp_func_ff;
   assign rsp_ch.pdu_length          = rsp_plen_ff;
   assign rsp_ch.is_broadcast        = rsp_bcast_ff;
   assign rsp_ch.bus_message_count   = bus_cnt_ff;
   assign rsp_ch.comm_error_count    = comm_cnt_ff;
   assign rsp_ch.slave_message_count = slave_cnt_ff;
   assign rsp_ch.no_response_count   = nores_cnt_ff;

endmodule
